// ===== rtl/sine_cosine_polynomial_unit_assert.svh =====
// assertion macros for the sine and cosine polynomial unit
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef SINE_COSINE_POLYNOMIAL_UNIT_ASSERT_SVH
`define SINE_COSINE_POLYNOMIAL_UNIT_ASSERT_SVH

// condition holds in the same cycle
`define SCPU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the following cycle
`define SCPU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/scpu_pkg.sv =====
// types, constants and rounding helpers for the sine and cosine polynomial unit
// used by every rtl module of the block, depends on nothing
`default_nettype none

package scpu_pkg;

  localparam int unsigned ANGLE_FRAC_BITS = 24;
  localparam int unsigned OUT_FRAC_BITS   = 30;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned Y2_W    = 33;
  localparam int unsigned ACC_W   = 34;
  localparam int unsigned YW      = 38;
  localparam int unsigned RW      = 80;
  localparam int unsigned N_CELLS = 5;

  localparam logic signed [DATA_W-1:0] INV_TWO_PI_Q32 = 32'sd683565276;
  localparam logic signed [35:0]       TWO_PI_Q32     = 36'sd26986075409;
  localparam logic signed [YW-1:0]     PI_Q32         = 38'sd13493037705;
  localparam logic signed [YW-1:0]     HALF_PI_Q32    = 38'sd6746518852;

  typedef logic signed [ACC_W-1:0] coef_t;

  // entry 0 seeds the accumulator, the last entry is one in q32
  localparam coef_t SIN_COEF [N_CELLS+1] = '{
    -34'sd103, 34'sd11822, -34'sd852159, 34'sd35791384, -34'sd715827897,
    34'sd4294967296
  };
  localparam coef_t COS_COEF [N_CELLS+1] = '{
    -34'sd1119, 34'sd106346, -34'sd5965013, 34'sd178956848, -34'sd2147483648,
    34'sd4294967296
  };

  typedef struct packed {
    logic                     valid;
    logic                     flip;
    logic signed [DATA_W-1:0] y30;
    logic signed [Y2_W-1:0]   y2;
    logic signed [ACC_W-1:0]  acc_s;
    logic signed [ACC_W-1:0]  acc_c;
  } lane_t;

  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] sine;
    logic signed [DATA_W-1:0] cosine;
  } res_t;

  // shift right by s, round to nearest with ties away from zero
  function automatic logic signed [RW-1:0] rnd_shr(input logic signed [RW-1:0] v,
                                                   input int unsigned s);
    logic signed [RW-1:0] half;
    logic signed [RW-1:0] adj;
    half = '0;
    half[s-1] = 1'b1;
    adj = '0;
    adj[0] = v[RW-1];
    return (v + half - adj) >>> s;
  endfunction

  // clamp to plus or minus 2^o
  function automatic logic signed [DATA_W-1:0] clamp_one(input logic signed [RW-1:0] v,
                                                         input int unsigned o);
    logic signed [RW-1:0] one;
    logic signed [RW-1:0] r;
    one = '0;
    one[o] = 1'b1;
    r = v;
    if (v > one) begin
      r = one;
    end else if (v < -one) begin
      r = -one;
    end
    return DATA_W'(r);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sine_cosine_polynomial_unit.sv =====
// top level of the sine and cosine polynomial unit: reduction, horner cells, finishing stages, output skid
// depends on scpu_pkg, scpu_reduce, scpu_cell, scpu_finish and the assertion macro header
//
// usage: one angle request enters on the s_axis group (tdata = angle, signed,
// ANGLE_FRAC_BITS fraction bits); one result request leaves on the m_axis group
// (tdata = sine in the low word, cosine in the high word, both signed with
// OUT_FRAC_BITS fraction bits and clamped to plus or minus one).
// stages: 21 register stages from the accepting edge to m_axis_tvalid, the first
// loaded at the accepting edge: eight reduction stages, five horner cells of two
// stages each, two finishing stages and the output register.
// throughput: one request per cycle while the skid stage is empty; every stage
// before the output register is in one chain and all of them advance together.
// stall: the output register is backed by a one-entry skid stage, so the chain
// keeps taking requests while a result waits; once the skid stage is full the
// chain and s_axis_tready hold until the receiver takes a result.
// reset: clears every valid flag, nothing is presented and all requests in
// flight are dropped.
`default_nettype none
`include "sine_cosine_polynomial_unit_assert.svh"

module sine_cosine_polynomial_unit #(
  parameter int unsigned ANGLE_FRAC_BITS = scpu_pkg::ANGLE_FRAC_BITS,
  parameter int unsigned OUT_FRAC_BITS   = scpu_pkg::OUT_FRAC_BITS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] angle
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata    // [31:0] sine, [63:32] cosine
);

  localparam int unsigned DW = scpu_pkg::DATA_W;
  localparam int unsigned NC = scpu_pkg::N_CELLS;
  localparam logic signed [DW-1:0] OUT_ONE = DW'(1) << OUT_FRAC_BITS;

  logic            en;
  scpu_pkg::lane_t lanes [NC+1];
  scpu_pkg::res_t  fin;
  scpu_pkg::res_t  out_d, out_q, skid_d, skid_q;
  logic            out_v_d, out_v_q, skid_v_d, skid_v_q;
  logic signed [DW-1:0] sine_w, cosine_w;

  assign en = !skid_v_q;

  scpu_reduce #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_reduce (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(s_axis_tvalid),
    .angle_i($signed(s_axis_tdata)),
    .lane_o (lanes[0])
  );

  for (genvar i = 0; i < NC; i++) begin : g_cell
    scpu_cell #(
      .IDX(i + 1)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .lane_i(lanes[i]),
      .lane_o(lanes[i+1])
    );
  end

  scpu_finish #(
    .OUT_FRAC_BITS(OUT_FRAC_BITS)
  ) u_finish (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (en),
    .lane_i(lanes[NC]),
    .res_o (fin)
  );

  // output register with skid stage
  always_comb begin
    out_d    = out_q;
    out_v_d  = out_v_q;
    skid_d   = skid_q;
    skid_v_d = skid_v_q;
    if (m_axis_tready || !out_v_q) begin
      if (skid_v_q) begin
        out_d    = skid_q;
        out_v_d  = 1'b1;
        skid_v_d = 1'b0;
      end else begin
        out_d   = fin;
        out_v_d = fin.valid;
      end
    end else if (fin.valid && !skid_v_q) begin
      skid_d   = fin;
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
      out_q    <= '0;
      skid_q   <= '0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
      out_q    <= out_d;
      skid_q   <= skid_d;
    end
  end

  assign s_axis_tready = en;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_q.cosine, out_q.sine};

  assign sine_w   = out_q.sine;
  assign cosine_w = out_q.cosine;

  `SCPU_ASSERT_NOW(a_skid_behind_out, skid_v_q, out_v_q, "skid stage full with output empty")
  `SCPU_ASSERT_NEXT(a_skid_drains, skid_v_q && m_axis_tready, !skid_v_q, "skid stage not drained")
  `SCPU_ASSERT_NEXT(a_result_kept, fin.valid && en, out_v_q, "finished result lost")
  `SCPU_ASSERT_NOW(a_out_range, out_v_q,
                   sine_w <= OUT_ONE && sine_w >= -OUT_ONE &&
                   cosine_w <= OUT_ONE && cosine_w >= -OUT_ONE,
                   "result beyond plus or minus one")

endmodule

`default_nettype wire

// ===== rtl/scpu_reduce.sv =====
// range reduction, fold and squaring of the angle, eight register stages
// depends on scpu_pkg, feeds the first horner cell
`default_nettype none

module scpu_reduce #(
  parameter int unsigned ANGLE_FRAC_BITS = scpu_pkg::ANGLE_FRAC_BITS
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   en_i,
  input  wire logic                                   valid_i,
  input  wire logic signed [scpu_pkg::DATA_W-1:0]     angle_i,
  output scpu_pkg::lane_t                             lane_o
);

  localparam int unsigned TURN_W = 32 - ANGLE_FRAC_BITS;
  localparam int unsigned AW     = 65 - ANGLE_FRAC_BITS;
  localparam int unsigned DW     = scpu_pkg::DATA_W;
  localparam int unsigned YW     = scpu_pkg::YW;
  localparam int unsigned RW     = scpu_pkg::RW;

  logic                     v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;
  logic signed [DW-1:0]     a1_q, a2_q, a3_q;
  logic signed [63:0]       p1_d, p1_q;
  logic signed [TURN_W-1:0] t2_d, t2_q;
  logic signed [AW-1:0]     m3_d, m3_q;
  logic signed [YW-1:0]     y4_d, y4_q;
  logic signed [YW-1:0]     y5_d, y5_q;
  logic                     f5_d, f5_q, f6_q, f7_q;
  logic signed [DW-1:0]     y30_6_d, y30_6_q, y30_7_q;
  logic signed [63:0]       sq7_d, sq7_q;
  scpu_pkg::lane_t          lane_d, lane_q;

  always_comb begin
    p1_d = angle_i * scpu_pkg::INV_TWO_PI_Q32;
    t2_d = TURN_W'(scpu_pkg::rnd_shr(RW'(p1_q), ANGLE_FRAC_BITS + 32));
    m3_d = AW'(t2_q) * AW'(scpu_pkg::TWO_PI_Q32);
    y4_d = YW'((AW'(a3_q) <<< (32 - ANGLE_FRAC_BITS)) - m3_q);
    // fold about plus or minus pi beyond a quarter turn
    y5_d = y4_q;
    f5_d = 1'b0;
    if (y4_q > scpu_pkg::HALF_PI_Q32) begin
      y5_d = scpu_pkg::PI_Q32 - y4_q;
      f5_d = 1'b1;
    end else if (y4_q < -scpu_pkg::HALF_PI_Q32) begin
      y5_d = -scpu_pkg::PI_Q32 - y4_q;
      f5_d = 1'b1;
    end
    y30_6_d = DW'(scpu_pkg::rnd_shr(RW'(y5_q), 2));
    sq7_d   = y30_6_q * y30_6_q;
    lane_d.valid = v7_q;
    lane_d.flip  = f7_q;
    lane_d.y30   = y30_7_q;
    lane_d.y2    = scpu_pkg::Y2_W'(scpu_pkg::rnd_shr(RW'(sq7_q), 30));
    lane_d.acc_s = scpu_pkg::SIN_COEF[0];
    lane_d.acc_c = scpu_pkg::COS_COEF[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      v5_q    <= 1'b0;
      v6_q    <= 1'b0;
      v7_q    <= 1'b0;
      a1_q    <= '0;
      a2_q    <= '0;
      a3_q    <= '0;
      p1_q    <= '0;
      t2_q    <= '0;
      m3_q    <= '0;
      y4_q    <= '0;
      y5_q    <= '0;
      f5_q    <= 1'b0;
      f6_q    <= 1'b0;
      f7_q    <= 1'b0;
      y30_6_q <= '0;
      y30_7_q <= '0;
      sq7_q   <= '0;
      lane_q  <= '0;
    end else if (en_i) begin
      v1_q    <= valid_i;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      v5_q    <= v4_q;
      v6_q    <= v5_q;
      v7_q    <= v6_q;
      a1_q    <= angle_i;
      a2_q    <= a1_q;
      a3_q    <= a2_q;
      p1_q    <= p1_d;
      t2_q    <= t2_d;
      m3_q    <= m3_d;
      y4_q    <= y4_d;
      y5_q    <= y5_d;
      f5_q    <= f5_d;
      f6_q    <= f5_q;
      f7_q    <= f6_q;
      y30_6_q <= y30_6_d;
      y30_7_q <= y30_6_q;
      sq7_q   <= sq7_d;
      lane_q  <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

`default_nettype wire

// ===== rtl/scpu_cell.sv =====
// one horner step for sine and cosine side by side, multiply then round and add
// depends on scpu_pkg, chained between scpu_reduce and scpu_finish
`default_nettype none

module scpu_cell #(
  parameter int unsigned IDX = 1
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       en_i,
  input  scpu_pkg::lane_t lane_i,
  output scpu_pkg::lane_t lane_o
);

  localparam int unsigned PW = scpu_pkg::ACC_W + scpu_pkg::Y2_W;
  localparam int unsigned RW = scpu_pkg::RW;

  logic                                va_q;
  logic                                fa_q;
  logic signed [scpu_pkg::DATA_W-1:0]  y30_a_q;
  logic signed [scpu_pkg::Y2_W-1:0]    y2_a_q;
  logic signed [PW-1:0]                ps_d, ps_q, pc_d, pc_q;
  scpu_pkg::lane_t                     lane_d, lane_q;

  always_comb begin
    ps_d = lane_i.acc_s * lane_i.y2;
    pc_d = lane_i.acc_c * lane_i.y2;
    lane_d.valid = va_q;
    lane_d.flip  = fa_q;
    lane_d.y30   = y30_a_q;
    lane_d.y2    = y2_a_q;
    lane_d.acc_s = scpu_pkg::ACC_W'(scpu_pkg::rnd_shr(RW'(ps_q), 30)
                   + RW'(scpu_pkg::SIN_COEF[IDX]));
    lane_d.acc_c = scpu_pkg::ACC_W'(scpu_pkg::rnd_shr(RW'(pc_q), 30)
                   + RW'(scpu_pkg::COS_COEF[IDX]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q    <= 1'b0;
      fa_q    <= 1'b0;
      y30_a_q <= '0;
      y2_a_q  <= '0;
      ps_q    <= '0;
      pc_q    <= '0;
      lane_q  <= '0;
    end else if (en_i) begin
      va_q    <= lane_i.valid;
      fa_q    <= lane_i.flip;
      y30_a_q <= lane_i.y30;
      y2_a_q  <= lane_i.y2;
      ps_q    <= ps_d;
      pc_q    <= pc_d;
      lane_q  <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

`default_nettype wire

// ===== rtl/scpu_finish.sv =====
// final sine multiply, output rounding, cosine sign and clamping, two stages
// depends on scpu_pkg, takes the lane from the last horner cell
`default_nettype none

module scpu_finish #(
  parameter int unsigned OUT_FRAC_BITS = scpu_pkg::OUT_FRAC_BITS
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       en_i,
  input  scpu_pkg::lane_t lane_i,
  output scpu_pkg::res_t  res_o
);

  localparam int unsigned PW = scpu_pkg::ACC_W + scpu_pkg::DATA_W;
  localparam int unsigned RW = scpu_pkg::RW;
  localparam int unsigned AW = scpu_pkg::ACC_W;

  logic                 va_q;
  logic                 fa_q;
  logic signed [PW-1:0] ps_d, ps_q;
  logic signed [AW-1:0] cr_d, cr_q;
  logic signed [RW-1:0] cf;
  scpu_pkg::res_t       res_d, res_q;

  always_comb begin
    ps_d = lane_i.acc_s * lane_i.y30;
    cr_d = AW'(scpu_pkg::rnd_shr(RW'(lane_i.acc_c), 32 - OUT_FRAC_BITS));
    cf   = fa_q ? -RW'(cr_q) : RW'(cr_q);
    res_d.valid  = va_q;
    res_d.sine   = scpu_pkg::clamp_one(scpu_pkg::rnd_shr(RW'(ps_q), 62 - OUT_FRAC_BITS),
                                       OUT_FRAC_BITS);
    res_d.cosine = scpu_pkg::clamp_one(cf, OUT_FRAC_BITS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q  <= 1'b0;
      fa_q  <= 1'b0;
      ps_q  <= '0;
      cr_q  <= '0;
      res_q <= '0;
    end else if (en_i) begin
      va_q  <= lane_i.valid;
      fa_q  <= lane_i.flip;
      ps_q  <= ps_d;
      cr_q  <= cr_d;
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

// ===== tb/sine_cosine_polynomial_unit_tb.sv =====
// testbench for sine_cosine_polynomial_unit: drives angle requests, predicts sine and
// cosine in fixed point and checks each result request in order
// depends on the rtl of the block only
`default_nettype none

module sine_cosine_polynomial_unit_tb;

  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned SETTLE       = 60;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned PHASE_ITEMS  = 390;
  localparam int unsigned BURST_ITEMS  = 60;
  localparam int          EIGHT_PI_Q24 = 421657428;
  localparam int          HALF_PI_Q24  = 26353589;

  typedef struct packed {
    logic signed [31:0] cosine;
    logic signed [31:0] sine;
  } sincos_t;

  class trig_scoreboard;
    localparam longint INV_TWO_PI_Q32 = 64'sd683565276;
    localparam longint TWO_PI_Q32     = 64'sd26986075409;
    localparam longint PI_Q32         = 64'sd13493037705;
    localparam longint HALF_PI_Q32    = 64'sd6746518852;
    localparam longint ONE_Q32        = 64'sd4294967296;
    localparam longint ONE_Q30        = 64'sd1073741824;

    sincos_t     expected_q[$];
    int unsigned checked;
    int unsigned mismatches;

    function longint rnd_shift(input longint v, input int unsigned s);
      longint unsigned mag;
      bit              neg;
      neg = v < 0;
      mag = neg ? -v : v;
      mag = (mag + (64'd1 << (s - 1))) >> s;
      return neg ? -longint'(mag) : longint'(mag);
    endfunction

    function longint horner_eval(input longint coef[5], input longint y2);
      longint acc;
      acc = coef[0];
      for (int i = 1; i < 5; i++) begin
        acc = rnd_shift(acc * y2, 30) + coef[i];
      end
      return rnd_shift(acc * y2, 30) + ONE_Q32;
    endfunction

    function longint clamp_unit(input longint v);
      if (v > ONE_Q30) begin
        return ONE_Q30;
      end
      if (v < -ONE_Q30) begin
        return -ONE_Q30;
      end
      return v;
    endfunction

    function sincos_t sincos_predict(input logic [31:0] angle);
      longint  sin_terms[5];
      longint  cos_terms[5];
      longint  a, turns, y, y30, y2, s, c;
      bit      folded;
      sincos_t r;
      sin_terms = '{-103, 11822, -852159, 35791384, -715827897};
      cos_terms = '{-1119, 106346, -5965013, 178956848, -64'sd2147483648};
      a = $signed(angle);
      turns = rnd_shift(a * INV_TWO_PI_Q32, 56);
      y = a * 256 - turns * TWO_PI_Q32;
      folded = 1'b0;
      if (y > HALF_PI_Q32) begin
        y = PI_Q32 - y;
        folded = 1'b1;
      end else if (y < -HALF_PI_Q32) begin
        y = -PI_Q32 - y;
        folded = 1'b1;
      end
      y30 = rnd_shift(y, 2);
      y2 = rnd_shift(y30 * y30, 30);
      s = rnd_shift(horner_eval(sin_terms, y2) * y30, 32);
      c = rnd_shift(horner_eval(cos_terms, y2), 2);
      if (folded) begin
        c = -c;
      end
      r.sine = 32'(clamp_unit(s));
      r.cosine = 32'(clamp_unit(c));
      return r;
    endfunction

    function void note_angle(input logic [31:0] angle);
      expected_q.push_back(sincos_predict(angle));
    endfunction

    function void check_result(input logic [63:0] data);
      sincos_t got;
      sincos_t exp_r;
      got = data;
      if (expected_q.size() == 0) begin
        $error("unexpected result request: sine %0d, cosine %0d", got.sine, got.cosine);
        mismatches++;
        return;
      end
      exp_r = expected_q.pop_front();
      checked++;
      if (got.sine !== exp_r.sine) begin
        $error("sine: expected %0d, actual %0d", exp_r.sine, got.sine);
        mismatches++;
      end
      if (got.cosine !== exp_r.cosine) begin
        $error("cosine: expected %0d, actual %0d", exp_r.cosine, got.cosine);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [31:0] angle
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // [31:0] sine, [63:32] cosine

  trig_scoreboard sb = new();
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_stall_pct = 0;
  int unsigned    angles_sent = 0;
  int unsigned    cycle_count = 0;
  bit             recv_held = 1'b0;
  event           hold_off_ev;

  sine_cosine_polynomial_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever begin
      #5 clk_i = ~clk_i;
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                 sb.pending());
        $display("tb: failure");
        $finish;
      end
    end
  end

  // long receiver hold-off, counted here
  initial begin
    forever begin
      @(hold_off_ev);
      recv_held = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      recv_held = 1'b0;
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata);
      end
      m_axis_tready <= !recv_held && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_angle(input logic [31:0] angle);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= angle;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_angle(angle);
    angles_sent++;
  endtask

  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] random_angle();
    int unsigned pick;
    int          n;
    pick = $urandom_range(99);
    if (pick < 40) begin
      return $urandom;
    end else if (pick < 70) begin
      return $urandom_range(2 * EIGHT_PI_Q24) - EIGHT_PI_Q24;
    end else if (pick < 85) begin
      // close to multiples of a quarter turn
      n = $urandom_range(160) - 80;
      return n * HALF_PI_Q24 + $urandom_range(8) - 4;
    end else if (pick < 93) begin
      return 32'h7FFFFFFF - $urandom_range(255);
    end
    return 32'h80000000 + $urandom_range(255);
  endfunction

  task automatic run_phase(input int unsigned n, input int unsigned idle_pct,
                           input int unsigned stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) send_angle(random_angle());
  endtask

  initial begin
    int directed[] = '{
      0, 1, -1, 32'h7FFFFFFF, 32'h80000000, 16777216, HALF_PI_Q24, -HALF_PI_Q24,
      52707179, -52707179, 79060768, 105414357, -105414357,
      // remainder lands exactly on plus or minus a quarter turn, then one step to either side of it
      -395303839, -395303838, -395303840, 395303839, 395303838, 395303840,
      32'h40000000, 32'hC0000000, 32'h55555555, 32'hAAAAAAAA
    };
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      send_angle(directed[i]);
    end

    run_phase(PHASE_ITEMS, 0, 0);

    // fill the pipeline against a stalled receiver, then let it drain
    -> hold_off_ev;
    run_phase(BURST_ITEMS, 0, 0);
    wait_all_results();

    run_phase(PHASE_ITEMS, 83, 0);
    run_phase(PHASE_ITEMS, 0, 83);
    run_phase(PHASE_ITEMS, 13, 13);

    wait_all_results();
    repeat (SETTLE) @(posedge clk_i);

    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
    end
    $display("summary: %0d angles sent, %0d results checked, %0d mismatches, %0d cycles",
             angles_sent, sb.checked, sb.mismatches, cycle_count);
    $display("summary: extremes, quarter-turn boundaries, random angles under idle and stall");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
